// ----- sv/dgl_pkg.sv -----
// Package for the dependency graph leveler: action codes, walk states, sizes.
// No dependencies.
`default_nettype none
package dgl_pkg;
  localparam int DglMaxNodes = 64;
  localparam int DglMaxEdges = 256;

  typedef enum logic [1:0] {
    ACT_ADD_NODE = 2'd0,
    ACT_ADD_EDGE = 2'd1,
    ACT_DISCOVER = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ROOT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_TGT_RD,
    ST_TGT_CHK,
    ST_FIN,
    ST_EMIT,
    ST_PARENT
  } walk_state_t;
endpackage
`default_nettype wire

// ----- sv/dgl_if.sv -----
// Valid/ready channel interfaces for the leveler's command and result items.
// Depends on nothing.
`default_nettype none
interface dgl_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [5:0] first_node;
  logic [5:0] second_node;
  modport source (output valid, action, first_node, second_node, input ready);
  modport sink (input valid, action, first_node, second_node, output ready);
endinterface

interface dgl_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] node_index;
  logic [5:0] node_level;
  logic [6:0] finish_order;
  logic       cycle_seen;
  logic       edges_dropped;
  logic       last;
  modport source (output valid, node_index, node_level, finish_order, cycle_seen,
                  edges_dropped, last, input ready);
  modport sink (input valid, node_index, node_level, finish_order, cycle_seen,
                edges_dropped, last, output ready);
endinterface
`default_nettype wire

// ----- sv/dependency_graph_dfs_leveler_unit.sv -----
// Top level of the dependency graph leveler: depth-first post-order walk.
// Depends on dgl_pkg and the channel interfaces in dgl_if.sv.
//
//   channel | direction | carries
//   in      | sink      | action, first_node, second_node
//   out     | source    | node_index, node_level, finish_order, cycle_seen, ...
//   cfg     | write     | invert_edges
//
// An add node item holds the input while it marks its node present, and an add edge item
// while it marks both ends, one after the other (one node when both ends are the same
// node). A clear sweeps the node memory, one entry a cycle. A discover scans the edge
// entries one by one for each open node, since the edge memory has one read port, and
// examines each root index in turn. Results sit in an output register; the walk waits
// while it is full.
// Reset is synchronous and starts the same node sweep as a clear.
`default_nettype none
module dependency_graph_dfs_leveler_unit
  import dgl_pkg::*;
#(
  parameter int MAX_NODES = DglMaxNodes,
  parameter int MAX_EDGES = DglMaxEdges
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dgl_cmd_if.sink   in_ch,
  dgl_res_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);

  // Node memory word: level(7) order(7) on_stack(1) present(1)
  typedef struct packed {
    logic [6:0] level;
    logic [6:0] order;
    logic       onstk;
    logic       pres;
  } node_t;

  logic [5:0]  esrc_mem [MAX_EDGES];
  logic [5:0]  etgt_mem [MAX_EDGES];
  node_t       node_mem [MAX_NODES];
  logic [NW+CW:0] stk_mem [MAX_NODES];  // node, scan position, cycle flag

  logic        invert_r;
  logic [CW-1:0] ecnt_r, ecnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic [6:0]  ordc_r, ordc_nxt;
  walk_state_t st_r, st_nxt;
  logic [NW:0] sp_r, sp_nxt;
  logic [NW-1:0] cur_r, cur_nxt, tgt_r, tgt_nxt, root_r, root_nxt, clr_r, clr_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic        cyc_r, cyc_nxt, any_r, any_nxt, lastpend_r, lastpend_nxt;
  node_t       curn_r, curn_nxt;
  logic [1:0]  act_r;
  logic [5:0]  a_r, b_r;

  // Memory ports
  logic          e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  logic [5:0]    e_wsrc, e_wtgt, e_rsrc, e_rtgt;
  logic          n_we;
  logic [NW-1:0] n_waddr, n_raddr;
  node_t         n_wdata, n_rdata;
  logic          s_we;
  logic [NW-1:0] s_waddr, s_raddr;
  logic [NW+CW:0] s_wdata, s_rdata;

  always_ff @(posedge clk) begin
    if (e_we) begin
      esrc_mem[e_waddr] <= e_wsrc;
      etgt_mem[e_waddr] <= e_wtgt;
    end
    e_rsrc <= esrc_mem[e_raddr];
    e_rtgt <= etgt_mem[e_raddr];
    if (n_we) node_mem[n_waddr] <= n_wdata;
    n_rdata <= node_mem[n_raddr];
    if (s_we) stk_mem[s_waddr] <= s_wdata;
    s_rdata <= stk_mem[s_raddr];
  end

  // Result register
  logic       ov_r, ov_nxt;
  logic [5:0] oi_r, oi_nxt, ol_r, ol_nxt;
  logic [6:0] oo_r, oo_nxt;
  logic       oc_r, oc_nxt, od_r, od_nxt, olst_r, olst_nxt;
  // One result is held back so that its last flag is known when it leaves.
  logic       hv_r, hv_nxt;
  logic [5:0] hi_r, hi_nxt, hl_r, hl_nxt;
  logic [6:0] ho_r, ho_nxt;
  logic       hc_r, hc_nxt, hd_r, hd_nxt;

  assign out_ch.valid         = ov_r;
  assign out_ch.node_index    = oi_r;
  assign out_ch.node_level    = ol_r;
  assign out_ch.finish_order  = oo_r;
  assign out_ch.cycle_seen    = oc_r;
  assign out_ch.edges_dropped = od_r;
  assign out_ch.last          = olst_r;
  assign in_ch.ready          = (st_r == ST_IDLE) && !lastpend_r;

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  logic a_ok, b_ok;
  assign a_ok = ({1'b0, in_ch.first_node} < 7'(MAX_NODES));
  assign b_ok = ({1'b0, in_ch.second_node} < 7'(MAX_NODES));

  always_comb begin
    logic out_free;
    logic [6:0] lv;
    st_nxt = st_r; sp_nxt = sp_r; cur_nxt = cur_r; tgt_nxt = tgt_r;
    root_nxt = root_r; clr_nxt = clr_r; pos_nxt = pos_r; cyc_nxt = cyc_r;
    any_nxt = any_r; lastpend_nxt = lastpend_r; curn_nxt = curn_r;
    ecnt_nxt = ecnt_r; ovf_nxt = ovf_r; ordc_nxt = ordc_r;
    ov_nxt = ov_r; oi_nxt = oi_r; ol_nxt = ol_r; oo_nxt = oo_r; oc_nxt = oc_r;
    od_nxt = od_r; olst_nxt = olst_r;
    hv_nxt = hv_r; hi_nxt = hi_r; hl_nxt = hl_r; ho_nxt = ho_r; hc_nxt = hc_r;
    hd_nxt = hd_r;
    e_we = 1'b0; e_waddr = ecnt_r[EW-1:0]; e_raddr = pos_r[EW-1:0];
    e_wsrc = in_ch.first_node; e_wtgt = in_ch.second_node;
    n_we = 1'b0; n_waddr = cur_r; n_raddr = cur_r; n_wdata = curn_r;
    s_we = 1'b0; s_waddr = sp_r[NW-1:0]; s_raddr = sp_r[NW-1:0]; s_wdata = '0;
    lv = '0;

    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    out_free = !ov_nxt;

    // Release the held result with last set once the walk is over.
    if (lastpend_r && out_free) begin
      ov_nxt = 1'b1; oi_nxt = hi_r; ol_nxt = hl_r; oo_nxt = ho_r; oc_nxt = hc_r;
      od_nxt = hd_r; olst_nxt = 1'b1; hv_nxt = 1'b0; lastpend_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (action_t'(in_ch.action))
            ACT_ADD_NODE: begin
              if (a_ok) begin
                cur_nxt = in_ch.first_node[NW-1:0];
                n_raddr = in_ch.first_node[NW-1:0];
                st_nxt = ST_SCAN_RD;  // reused as read-then-mark step
              end
            end
            ACT_ADD_EDGE: begin
              if (a_ok && b_ok) begin
                if (ecnt_r < CW'(MAX_EDGES)) begin
                  e_we = 1'b1;
                  e_wsrc = invert_r ? in_ch.second_node : in_ch.first_node;
                  e_wtgt = invert_r ? in_ch.first_node : in_ch.second_node;
                  ecnt_nxt = ecnt_r + 1'b1;
                end else begin
                  ovf_nxt = 1'b1;
                end
                cur_nxt = in_ch.first_node[NW-1:0];
                n_raddr = in_ch.first_node[NW-1:0];
                st_nxt = ST_SCAN_RD;
              end
            end
            ACT_DISCOVER: begin
              root_nxt = '0; any_nxt = 1'b0; n_raddr = '0; st_nxt = ST_ROOT;
            end
            ACT_CLEAR: begin
              clr_nxt = '0; ecnt_nxt = '0; ovf_nxt = 1'b0; ordc_nxt = '0;
              st_nxt = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        n_we = 1'b1; n_waddr = clr_r; n_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == NW'(MAX_NODES - 1)) st_nxt = ST_IDLE;
      end
      ST_ROOT: begin
        // n_rdata holds node root_r.
        if (n_rdata.pres && n_rdata.order == '0) begin
          cur_nxt = root_r; curn_nxt = n_rdata; curn_nxt.onstk = 1'b1;
          n_we = 1'b1; n_waddr = root_r; n_wdata = curn_nxt;
          pos_nxt = '0; cyc_nxt = 1'b0; sp_nxt = (NW+1)'(1);
          st_nxt = ST_SCAN_CHK; e_raddr = '0;
        end else if (root_r == NW'(MAX_NODES - 1)) begin
          st_nxt = ST_IDLE;
          if (any_r) lastpend_nxt = 1'b1;
        end else begin
          root_nxt = root_r + 1'b1; n_raddr = root_r + 1'b1;
        end
      end
      ST_SCAN_RD: begin
        // Add-node and add-edge path: mark the node read last cycle, then, for an edge, its second node.
        if (!n_rdata.pres) begin
          n_we = 1'b1; n_waddr = act_r == ACT_ADD_NODE ? a_r[NW-1:0] : cur_r;
          n_wdata = n_rdata; n_wdata.pres = 1'b1;
          if (act_r == ACT_ADD_NODE || cur_r == b_r[NW-1:0]) n_waddr = cur_r;
        end
        if (act_r == ACT_ADD_EDGE && cur_r != b_r[NW-1:0]) begin
          cur_nxt = b_r[NW-1:0]; n_raddr = b_r[NW-1:0];
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_SCAN_CHK: begin
        // e_raddr was pos_r last cycle; edge data valid now if pos_r < count.
        if (pos_r >= ecnt_r) begin
          st_nxt = ST_FIN;
        end else if (e_rsrc[NW-1:0] == cur_r && (NW == 6 || e_rsrc < 6'(MAX_NODES))) begin
          tgt_nxt = e_rtgt[NW-1:0]; n_raddr = e_rtgt[NW-1:0];
          pos_nxt = pos_r + 1'b1; st_nxt = ST_TGT_CHK;
        end else begin
          pos_nxt = pos_r + 1'b1; e_raddr = pos_nxt[EW-1:0];
        end
      end
      ST_TGT_RD: st_nxt = ST_TGT_CHK;
      ST_TGT_CHK: begin
        e_raddr = pos_r[EW-1:0];
        if (tgt_r == cur_r) begin
          cyc_nxt = 1'b1; st_nxt = ST_SCAN_CHK;
        end else if (n_rdata.onstk) begin
          cyc_nxt = 1'b1; st_nxt = ST_SCAN_CHK;
        end else if (n_rdata.order == '0) begin
          if (sp_r < (NW+1)'(MAX_NODES)) begin
            s_we = 1'b1; s_waddr = sp_r[NW-1:0] - 1'b1;
            s_wdata = {cur_r, pos_r, cyc_r};
            n_we = 1'b1; n_waddr = cur_r; n_wdata = curn_r;
            cur_nxt = tgt_r; curn_nxt = n_rdata; curn_nxt.onstk = 1'b1;
            pos_nxt = '0; cyc_nxt = 1'b0; sp_nxt = sp_r + 1'b1; e_raddr = '0;
          end
          st_nxt = ST_SCAN_CHK;
        end else begin
          if (curn_r.level < n_rdata.level) curn_nxt.level = n_rdata.level;
          st_nxt = ST_SCAN_CHK;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ordc_nxt = ordc_r + 1'b1;
          if (hv_r) begin
            ov_nxt = 1'b1; oi_nxt = hi_r; ol_nxt = hl_r; oo_nxt = ho_r;
            oc_nxt = hc_r; od_nxt = hd_r; olst_nxt = 1'b0;
          end
          hv_nxt = 1'b1; hi_nxt = 6'(cur_r); hl_nxt = curn_r.level[5:0];
          ho_nxt = ordc_nxt; hc_nxt = cyc_r; hd_nxt = ovf_r; any_nxt = 1'b1;
          lv = (curn_r.level < 7'd127) ? curn_r.level + 1'b1 : curn_r.level;
          n_we = 1'b1; n_waddr = cur_r;
          n_wdata = '{level: lv, order: ordc_nxt, onstk: 1'b0, pres: curn_r.pres};
          curn_nxt.level = lv;
          sp_nxt = sp_r - 1'b1;
          if (sp_r == 1) begin
            if (root_r == NW'(MAX_NODES - 1)) begin
              st_nxt = ST_IDLE; lastpend_nxt = 1'b1;
            end else begin
              root_nxt = root_r + 1'b1; n_raddr = root_r + 1'b1; st_nxt = ST_EMIT;
            end
          end else begin
            s_raddr = sp_r[NW-1:0] - 2'd2; st_nxt = ST_PARENT;
          end
        end
      end
      ST_EMIT: begin
        n_raddr = root_r; st_nxt = ST_ROOT;
      end
      ST_PARENT: begin
        // s_rdata holds the parent frame; reload its node word.
        {cur_nxt, pos_nxt, cyc_nxt} = s_rdata;
        n_raddr = s_rdata[NW+CW:CW+1]; tgt_nxt = cur_r; st_nxt = ST_EMIT;
        st_nxt = ST_TGT_RD;
        lastpend_nxt = lastpend_r;
      end
      default: st_nxt = ST_IDLE;
    endcase

    // After a parent reload, take its node word and fold in the child level.
    if (st_r == ST_TGT_RD) begin
      curn_nxt = n_rdata;
      if (n_rdata.level < curn_r.level) curn_nxt.level = curn_r.level;
      e_raddr = pos_r[EW-1:0];
      st_nxt = ST_SCAN_CHK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= '0; invert_r <= 1'b0; ecnt_r <= '0; ovf_r <= 1'b0;
      ordc_r <= '0; sp_r <= '0; ov_r <= 1'b0; hv_r <= 1'b0; lastpend_r <= 1'b0;
      any_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; ecnt_r <= ecnt_nxt; ovf_r <= ovf_nxt;
      ordc_r <= ordc_nxt; sp_r <= sp_nxt; ov_r <= ov_nxt; hv_r <= hv_nxt;
      lastpend_r <= lastpend_nxt; any_r <= any_nxt;
      if (cfg_we) invert_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; tgt_r <= tgt_nxt; root_r <= root_nxt; pos_r <= pos_nxt;
    cyc_r <= cyc_nxt; curn_r <= curn_nxt;
    oi_r <= oi_nxt; ol_r <= ol_nxt; oo_r <= oo_nxt; oc_r <= oc_nxt; od_r <= od_nxt;
    olst_r <= olst_nxt;
    hi_r <= hi_nxt; hl_r <= hl_nxt; ho_r <= ho_nxt; hc_r <= hc_nxt; hd_r <= hd_nxt;
    if (in_fire) begin
      act_r <= in_ch.action; a_r <= in_ch.first_node; b_r <= in_ch.second_node;
    end
  end
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for dependency_graph_dfs_leveler_unit: a directed table,
// then random graph loads with discovers, checked against an in-bench graph walker.
// Depends on dgl_pkg, dgl_if.sv and the leveler top level.
`default_nettype none
module testbench;
  import dgl_pkg::*;

  typedef struct packed {
    logic [5:0] node_index;
    logic [5:0] node_level;
    logic [6:0] finish_order;
    logic       cycle_seen;
    logic       edges_dropped;
    logic       last;
  } leveled_node_t;

  typedef struct packed {
    action_t       act;
    logic [5:0]    a;
    logic [5:0]    b;
    logic          typed;
    leveled_node_t lit;
  } cmd_row_t;

  localparam int CycleLimit = 1500000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  dgl_cmd_if cmd();
  dgl_res_if res();

  dependency_graph_dfs_leveler_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(cmd), .out_ch(res),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the graph tables and walk state.
  logic [5:0] sh_src [DglMaxEdges];
  logic [5:0] sh_tgt [DglMaxEdges];
  int         sh_edge_count;
  bit         sh_present [DglMaxNodes];
  int         sh_level [DglMaxNodes];
  int         sh_order [DglMaxNodes];
  bit         sh_open [DglMaxNodes];
  int         stk_node [DglMaxNodes];
  int         stk_pos [DglMaxNodes];
  bit         stk_cyc [DglMaxNodes];
  int         sh_order_ctr;
  bit         sh_dropped;
  bit         sh_invert;

  leveled_node_t leveled_q[$];
  int  fail_count;
  int  cycle_count;
  bit  quiet;
  int  stall_left;
  int  base_node;
  int  graph_nodes;

  cmd_row_t dir_tab [20] = '{
    '{ACT_DISCOVER, 6'd0,  6'd0,  1'b0, '0},
    '{ACT_ADD_NODE, 6'd63, 6'd0,  1'b0, '0},
    '{ACT_DISCOVER, 6'd0,  6'd0,  1'b1, '{6'd63, 6'd0, 7'd1, 1'b0, 1'b0, 1'b1}},
    '{ACT_ADD_NODE, 6'd63, 6'd63, 1'b0, '0},
    '{ACT_DISCOVER, 6'd63, 6'd63, 1'b0, '0},
    '{ACT_CLEAR,    6'd0,  6'd0,  1'b0, '0},
    '{ACT_ADD_EDGE, 6'd0,  6'd63, 1'b0, '0},
    '{ACT_DISCOVER, 6'd0,  6'd0,  1'b0, '0},
    '{ACT_ADD_EDGE, 6'd5,  6'd5,  1'b0, '0},
    '{ACT_DISCOVER, 6'd0,  6'd0,  1'b1, '{6'd5, 6'd0, 7'd3, 1'b1, 1'b0, 1'b1}},
    '{ACT_ADD_EDGE, 6'd10, 6'd11, 1'b0, '0},
    '{ACT_ADD_EDGE, 6'd11, 6'd12, 1'b0, '0},
    '{ACT_ADD_EDGE, 6'd12, 6'd10, 1'b0, '0},
    '{ACT_ADD_EDGE, 6'd11, 6'd63, 1'b0, '0},
    '{ACT_DISCOVER, 6'd42, 6'd21, 1'b0, '0},
    '{ACT_CLEAR,    6'd63, 6'd63, 1'b0, '0},
    '{ACT_DISCOVER, 6'd0,  6'd0,  1'b0, '0},
    '{ACT_ADD_EDGE, 6'd42, 6'd21, 1'b0, '0},
    '{ACT_ADD_EDGE, 6'd21, 6'd0,  1'b0, '0},
    '{ACT_DISCOVER, 6'd0,  6'd0,  1'b0, '0}
  };

  task automatic clear_graph();
    sh_edge_count = 0;
    sh_order_ctr  = 0;
    sh_dropped    = 1'b0;
    for (int i = 0; i < DglMaxNodes; i++) begin
      sh_present[i] = 1'b0;
      sh_level[i]   = 0;
      sh_order[i]   = 0;
      sh_open[i]    = 1'b0;
    end
  endtask

  // Post-order walk of every unfinished node; queues one result per finished node.
  task automatic walk_graph();
    int sp, n, e, t, p;
    int produced;
    leveled_node_t r;
    produced = 0;
    for (int root = 0; root < DglMaxNodes; root++) begin
      if (!sh_present[root] || sh_order[root] != 0) continue;
      stk_node[0] = root;
      stk_pos[0]  = 0;
      stk_cyc[0]  = 1'b0;
      sh_open[root] = 1'b1;
      sp = 1;
      while (sp > 0) begin
        n = stk_node[sp-1];
        e = stk_pos[sp-1];
        while (e < sh_edge_count && sh_src[e] != n) e++;
        if (e < sh_edge_count) begin
          t = sh_tgt[e];
          stk_pos[sp-1] = e + 1;
          if (sh_open[t]) begin
            stk_cyc[sp-1] = 1'b1;
          end else if (sh_order[t] == 0) begin
            if (sp < DglMaxNodes) begin
              stk_node[sp] = t;
              stk_pos[sp]  = 0;
              stk_cyc[sp]  = 1'b0;
              sh_open[t]   = 1'b1;
              sp++;
            end
          end else if (sh_level[n] < sh_level[t]) begin
            sh_level[n] = sh_level[t];
          end
        end else begin
          sp--;
          sh_open[n] = 1'b0;
          sh_order_ctr = (sh_order_ctr + 1) & 127;
          sh_order[n] = sh_order_ctr;
          if (produced < DglMaxNodes) begin
            r.node_index    = n[5:0];
            r.node_level    = sh_level[n][5:0];
            r.finish_order  = sh_order_ctr[6:0];
            r.cycle_seen    = stk_cyc[sp];
            r.edges_dropped = sh_dropped;
            r.last          = 1'b0;
            leveled_q.push_back(r);
            produced++;
          end
          if (sh_level[n] < 127) sh_level[n]++;
          if (sp > 0) begin
            p = stk_node[sp-1];
            if (sh_level[p] < sh_level[n]) sh_level[p] = sh_level[n];
          end
        end
      end
    end
    if (produced > 0) leveled_q[$].last = 1'b1;
  endtask

  task automatic predict_item(action_t act, logic [5:0] a, logic [5:0] b);
    case (act)
      ACT_ADD_NODE: sh_present[a] = 1'b1;
      ACT_ADD_EDGE: begin
        sh_present[a] = 1'b1;
        sh_present[b] = 1'b1;
        if (sh_edge_count < DglMaxEdges) begin
          sh_src[sh_edge_count] = sh_invert ? b : a;
          sh_tgt[sh_edge_count] = sh_invert ? a : b;
          sh_edge_count++;
        end else begin
          sh_dropped = 1'b1;
        end
      end
      ACT_CLEAR: clear_graph();
      default: walk_graph();
    endcase
  endtask

  // Drives one item and waits for its acceptance; valid stays high afterward.
  task automatic send_item(action_t act, logic [5:0] a, logic [5:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.action      <= act;
    cmd.first_node  <= a;
    cmd.second_node <= b;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    predict_item(act, a, b);
  endtask

  task automatic drain_results();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (leveled_q.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only once the block has gone quiet, clear sweep included.
  task automatic write_invert(bit v);
    drain_results();
    repeat (120) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sh_invert = v;
  endtask

  function automatic logic [5:0] pick_node();
    return 6'((base_node + $urandom_range(0, graph_nodes - 1)) % DglMaxNodes);
  endfunction

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("dependency_graph_dfs_leveler_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res.ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      res.ready  <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    leveled_node_t want;
    if (rst_n && res.valid && res.ready) begin
      if (leveled_q.size() == 0) begin
        $error("unexpected item: node_index %0d", res.node_index);
        fail_count++;
      end else begin
        want = leveled_q.pop_front();
        if (res.node_index !== want.node_index) begin
          $error("node_index expected %0d actual %0d", want.node_index, res.node_index);
          fail_count++;
        end
        if (res.node_level !== want.node_level) begin
          $error("node_level expected %0d actual %0d", want.node_level, res.node_level);
          fail_count++;
        end
        if (res.finish_order !== want.finish_order) begin
          $error("finish_order expected %0d actual %0d", want.finish_order,
                 res.finish_order);
          fail_count++;
        end
        if (res.cycle_seen !== want.cycle_seen) begin
          $error("cycle_seen expected %0d actual %0d", want.cycle_seen, res.cycle_seen);
          fail_count++;
        end
        if (res.edges_dropped !== want.edges_dropped) begin
          $error("edges_dropped expected %0d actual %0d", want.edges_dropped,
                 res.edges_dropped);
          fail_count++;
        end
        if (res.last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, res.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int n_items;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    cmd.valid       = 1'b0;
    cmd.action      = ACT_ADD_NODE;
    cmd.first_node  = '0;
    cmd.second_node = '0;
    res.ready       = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    quiet           = 1'b0;
    stall_left      = 0;
    sh_invert       = 1'b0;
    clear_graph();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].act, dir_tab[i].a, dir_tab[i].b);
      if (dir_tab[i].typed) begin
        void'(leveled_q.pop_back());
        leveled_q.push_back(dir_tab[i].lit);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      write_invert(ph < 4 ? ph[0] : 1'($urandom_range(0, 1)));
      if (ph >= 10) quiet = 1'b1;
      if (ph < 2 || $urandom_range(0, 3) != 0) send_item(ACT_CLEAR, 6'($urandom), 6'($urandom));
      base_node   = $urandom_range(0, 63);
      graph_nodes = $urandom_range(1, 10);
      n_items     = $urandom_range(10, 18);
      for (int i = 0; i < n_items; i++) begin
        case ($urandom_range(0, 9))
          0, 1:    send_item(ACT_ADD_NODE, pick_node(), 6'($urandom));
          2:       send_item(action_t'($urandom_range(0, 3)), 6'($urandom), 6'($urandom));
          3:       send_item(ACT_DISCOVER, 6'($urandom), 6'($urandom));
          default: send_item(ACT_ADD_EDGE, pick_node(), pick_node());
        endcase
      end
      // In phase 5 the sender holds off here until the walk so far has fully drained.
      if (ph == 5) drain_results();
      send_item(ACT_DISCOVER, 6'($urandom), 6'($urandom));
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("dependency_graph_dfs_leveler_unit verification clean");
    end else begin
      $display("dependency_graph_dfs_leveler_unit verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
